[rtl/core/spl_pkg.sv]
// Shared constants, types and codes of the sorted priority list.
`default_nettype none
package spl_pkg;

	// Sizing
	localparam int CAPACITY     = 16;
	localparam int KEY_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int CNT_BITS     = $clog2(CAPACITY + 1);

	// Stream word widths, padded to whole bytes
	localparam int S_DATA_BITS = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS = 2 + KEY_BITS + PAYLOAD_BITS + CNT_BITS;
	localparam int M_DATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	typedef logic [KEY_BITS-1:0]     key_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam cnt_t CNT_CAPACITY = cnt_t'(CAPACITY);

	// Per-cell control from the top level
	typedef struct packed {
		logic ins;   // insert takes effect this cycle
		logic del;   // remove takes effect this cycle
		logic head;  // this cell is slot 0
		logic occ;   // this cell holds a stored entry
	} cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/sorted_priority_list.sv]
// Top level of the sorted priority list: stream ports, fill count and cell row.
`default_nettype none
// A bounded queue of up to CAPACITY (key, payload) entries kept in ascending
// key order in a row of cells, slot 0 being the head. Each input word is an
// insert (tuser 0) or a remove of the head (tuser 1); every word yields one
// result word with status, removed head entry and the occupancy afterwards.
// An insert goes before the head only when its key is strictly smaller, and
// otherwise after all entries with smaller keys (a new key equal to stored
// ones lands right behind the head or ahead of the other equal keys, so equal
// keys past the head come out newest first). All cells compare against the
// new key in parallel and shift in the same edge, so the result appears in
// the output register the cycle after the word is accepted, and a new word
// is accepted every cycle as long as the result register is free or drained.
// No clearing pass is needed after reset.
module sorted_priority_list
	import spl_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [S_DATA_BITS-1:0] s_tdata,   // key, payload
	input  wire                    s_tuser,   // cmd
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [M_DATA_BITS-1:0] m_tdata    // status, head_key, head_payload, occupancy
);

	cnt_t                   count_q;
	logic                   m_tvalid_q;
	logic [M_DATA_BITS-1:0] m_tdata_q;

	logic accept, full, empty, do_ins, do_del;
	key_t in_key;
	pay_t in_pay;

	key_t cell_key  [CAPACITY];
	pay_t cell_pay  [CAPACITY];
	logic cell_stay [CAPACITY];

	// Input word unpack
	assign in_key = s_tdata[KEY_BITS-1:0];
	assign in_pay = s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_CAPACITY);
	assign empty    = (count_q == '0);
	assign do_ins   = accept && (s_tuser == CMD_INSERT) && !full;
	assign do_del   = accept && (s_tuser == CMD_REMOVE) && !empty;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctrl_t ctrl;
		key_t       l_key, r_key;
		pay_t       l_pay, r_pay;
		logic       l_stay;

		assign ctrl = '{ins: do_ins, del: do_del, head: (i == 0),
			occ: (i < int'(count_q))};

		if (i == 0) begin : g_first
			assign l_key  = in_key;
			assign l_pay  = in_pay;
			assign l_stay = 1'b1;
		end else begin : g_mid
			assign l_key  = cell_key[i-1];
			assign l_pay  = cell_pay[i-1];
			assign l_stay = cell_stay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_key = cell_key[i];
			assign r_pay = cell_pay[i];
		end else begin : g_inner
			assign r_key = cell_key[i+1];
			assign r_pay = cell_pay[i+1];
		end

		spl_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_key   (in_key),
			.new_pay   (in_pay),
			.left_key  (l_key),
			.left_pay  (l_pay),
			.left_stay (l_stay),
			.right_key (r_key),
			.right_pay (r_pay),
			.key       (cell_key[i]),
			.pay       (cell_pay[i]),
			.stay      (cell_stay[i])
		);
	end

	// Result word build
	logic [1:0] res_status;
	key_t       res_key;
	pay_t       res_pay;
	cnt_t       next_count;

	always_comb begin
		res_status = ST_DONE;
		if (s_tuser == CMD_INSERT && full) begin
			res_status = ST_FULL;
		end else if (s_tuser == CMD_REMOVE && empty) begin
			res_status = ST_EMPTY;
		end
		res_key = do_del ? cell_key[0] : '0;
		res_pay = do_del ? cell_pay[0] : '0;
		next_count = count_q;
		if (do_ins) begin
			next_count = count_q + cnt_t'(1);
		end else if (do_del) begin
			next_count = count_q - cnt_t'(1);
		end
	end

	// Fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= next_count;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= M_DATA_BITS'({next_count, res_pay, res_key, res_status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

[rtl/core/spl_cell.sv]
// One slot of the sorted list: holds an entry and trades it with its neighbors.
`default_nettype none
module spl_cell
	import spl_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  key_t       new_key,
	input  pay_t       new_pay,
	input  key_t       left_key,
	input  pay_t       left_pay,
	input  logic       left_stay,
	input  key_t       right_key,
	input  pay_t       right_pay,
	output key_t       key,
	output pay_t       pay,
	output logic       stay
);

	key_t key_q;
	pay_t pay_q;

	// Entry stays in place on insert when it orders before the new key;
	// an equal key at the head also stays.
	assign stay = ctrl.occ && (ctrl.head ? (key_q <= new_key) : (key_q < new_key));

	// Insert: stay, take the new entry at the boundary, or shift right.
	// Remove: everything moves one slot toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!stay) begin
				if (left_stay) begin
					key_q <= new_key;
					pay_q <= new_pay;
				end else begin
					key_q <= left_key;
					pay_q <= left_pay;
				end
			end
		end else if (ctrl.del) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

	assign key = key_q;
	assign pay = pay_q;

endmodule
`default_nettype wire

[rtl/core/spl_checker.sv]
// Port-level checks of the sorted priority list, bound to the top level.
`default_nettype none
module spl_checker
	import spl_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire [S_DATA_BITS-1:0] s_tdata,
	input wire                   s_tuser,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [M_DATA_BITS-1:0] m_tdata
);

	logic [1:0] st;
	key_t       hk;
	pay_t       hp;
	cnt_t       occ;

	assign st  = m_tdata[1:0];
	assign hk  = m_tdata[KEY_BITS+1:2];
	assign hp  = m_tdata[KEY_BITS+PAYLOAD_BITS+1:KEY_BITS+2];
	assign occ = m_tdata[M_FIELD_BITS-1:KEY_BITS+PAYLOAD_BITS+2];

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Occupancy never exceeds capacity
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ <= CNT_CAPACITY)
		else $error("occupancy above capacity");

	// Refused commands report no entry
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_DONE |-> hk == '0 && hp == '0)
		else $error("refused command reports an entry");

	// Full refusal only at capacity, empty refusal only at zero
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == ST_DONE) || (st == ST_FULL && occ == CNT_CAPACITY) ||
			(st == ST_EMPTY && occ == '0))
		else $error("status does not match occupancy");

endmodule

bind sorted_priority_list spl_checker u_spl_checker (.*);
`default_nettype wire

[bench/spl_checker.sv]
// Checker for the sorted priority list: tracks the list, predicts each result word and compares.
`timescale 1ns / 1ps
module spl_tb_checker
	import spl_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	input  wire                    s_tready,
	input  wire  [S_DATA_BITS-1:0] s_tdata,   // key, payload
	input  wire                    s_tuser,   // cmd
	input  wire                    m_tvalid,
	input  wire                    m_tready,
	input  wire  [M_DATA_BITS-1:0] m_tdata,   // status, head_key, head_payload, occupancy
	output int                     fail_count,
	output int                     pending_count
);

	// Result word layout, last member lowest (status sits in bit 0 up)
	typedef struct packed {
		cnt_t       occupancy;
		pay_t       head_payload;
		key_t       head_key;
		logic [1:0] status;
	} list_result_t;

	// Shadow copy of the list, slot 0 is the head
	key_t list_keys [CAPACITY];
	pay_t list_pays [CAPACITY];
	int   list_fill = 0;

	list_result_t expected_results[$];
	int           mismatches = 0;

	// Apply one command to the shadow list and return the result word it yields
	task automatic apply_list_op(input logic cmd, input key_t key, input pay_t pay,
			output list_result_t res);
		int pos;
		res = '0;
		if (cmd == CMD_INSERT) begin
			if (list_fill >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// strictly smaller key goes to the head, else behind smaller keys
				if (list_fill == 0 || key < list_keys[0]) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < list_fill && list_keys[pos] < key)
						pos++;
				end
				for (int i = list_fill; i > pos; i--) begin
					list_keys[i] = list_keys[i-1];
					list_pays[i] = list_pays[i-1];
				end
				list_keys[pos] = key;
				list_pays[pos] = pay;
				list_fill++;
				res.status = ST_DONE;
			end
		end else begin
			if (list_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.head_key     = list_keys[0];
				res.head_payload = list_pays[0];
				for (int i = 1; i < list_fill; i++) begin
					list_keys[i-1] = list_keys[i];
					list_pays[i-1] = list_pays[i];
				end
				list_fill--;
				res.status = ST_DONE;
			end
		end
		res.occupancy = cnt_t'(list_fill);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare accepted result words first, then record new commands
	always @(posedge clk or negedge arst_n) begin : monitor
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			expected_results.delete();
			list_fill     = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = list_result_t'(m_tdata[M_FIELD_BITS-1:0]);
				if (expected_results.size() == 0) begin
					$display("%0t ns: result word with nothing expected, actual 0x%0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("head_key", 32'(want.head_key), 32'(got.head_key));
					check_field("head_payload", 32'(want.head_payload),
						32'(got.head_payload));
					check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
				end
			end
			if (s_tvalid && s_tready) begin
				apply_list_op(s_tuser, s_tdata[KEY_BITS-1:0],
					s_tdata[KEY_BITS +: PAYLOAD_BITS], want);
				expected_results.push_back(want);
			end
			fail_count    <= mismatches;
			pending_count <= expected_results.size();
		end
	end

endmodule

[bench/tb.sv]
// Testbench top for the sorted priority list: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module tb;
	import spl_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 40;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata  = '0;   // key, payload
	logic                   s_tuser  = 1'b0; // cmd
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;         // status, head_key, head_payload, occupancy

	int fail_count;
	int pending_count;

	sorted_priority_list uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spl_tb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: rotates through always-ready, random, short-stall and long-stall phases
	logic [9:0] rx_phase = '0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1'b1;
		case (rx_phase[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= (rx_phase[2:0] != 3'd0);
			default: m_tready <= (rx_phase[4:0] < 5'd8);
		endcase
	end

	// Watchdog: no word moving on either side for too long
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Sender burst state
	int burst_left = 0;
	int zero_gap_run = 0;

	// Offer one word and hold it until taken; gaps fall between bursts
	task automatic send_word(input logic cmd, input key_t key, input pay_t pay);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (zero_gap_run > 0) begin
				zero_gap_run--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0)
					zero_gap_run = $urandom_range(2, 8);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= S_DATA_BITS'({pay, key});
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int sent;
		int len;
		int ins_pct;
		int key_mode;
		logic cmd;
		key_t key;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, extremes, head and equal-key inserts, full
		send_word(CMD_REMOVE, 16'h1234, 32'h89ABCDEF);
		send_word(CMD_INSERT, 16'hFFFF, 32'hFFFFFFFF);
		send_word(CMD_INSERT, 16'h0000, 32'h00000000);
		send_word(CMD_INSERT, 16'h0000, 32'hA5A5A5A5);
		send_word(CMD_INSERT, 16'h8000, 32'h5A5A5A5A);
		for (int i = 0; i < 11; i++)
			send_word(CMD_INSERT, key_t'($urandom), pay_t'($urandom));
		send_word(CMD_INSERT, 16'h0001, 32'h12345678);
		send_word(CMD_INSERT, 16'h4321, 32'h87654321);
		for (int i = 0; i < 4; i++)
			send_word(CMD_REMOVE, '0, '0);

		// Random episodes with an insert bias and a key spread of their own
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len      = $urandom_range(10, 60);
			key_mode = $urandom_range(0, 2);
			case ($urandom_range(0, 4))
				0: ins_pct = 95;
				1: ins_pct = 75;
				2: ins_pct = 50;
				3: ins_pct = 25;
				default: ins_pct = 5;
			endcase
			for (int i = 0; i < len; i++) begin
				cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
				case (key_mode)
					0: key = key_t'($urandom);
					1: key = key_t'($urandom_range(0, 7));
					default: key = $urandom_range(0, 1) ? {KEY_BITS{1'b1}}
						: key_t'($urandom_range(0, 3));
				endcase
				send_word(cmd, key, pay_t'($urandom));
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then settle
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/spl_pkg.sv
rtl/core/spl_cell.sv
rtl/core/sorted_priority_list.sv
rtl/core/spl_checker.sv
bench/spl_checker.sv
bench/tb.sv
